// ===== sv/vital_sign_alarm_latch_core_macros.svh =====
// assertion helpers shared by the alarm latch core
`ifndef VITAL_SIGN_ALARM_LATCH_CORE_MACROS_SVH
`define VITAL_SIGN_ALARM_LATCH_CORE_MACROS_SVH

// condition holds at every clock edge out of reset
`define VSAL_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// consequent holds in the same cycle as the antecedent
`define VSAL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define VSAL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/vsal_pkg.sv =====
`timescale 1ns / 1ps

package vsal_pkg;

  // field widths
  localparam int TEMP_W   = 12;
  localparam int SET_W    = 10;
  localparam int CO2_W    = 16;
  localparam int HR_W     = 8;
  localparam int SAT_W    = 7;
  localparam int CNT_W    = 7;
  localparam int GRACE_W  = 6;
  localparam int ALARM_W  = 7;
  localparam int PHASE_W  = 4;
  localparam int CMP_W    = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_CHECKS = 7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_TEMPERATURE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_HUMIDITY      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_OXYGEN        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEMPERATURE_BAND     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HUMIDITY_BAND        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OXYGEN_BAND          = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CARBON_DIOXIDE_LIMIT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SATURATION_LIMIT     = 3'd7;

  // configuration reset values
  localparam logic [SET_W-1:0] RST_TARGET_TEMPERATURE   = 10'd370;
  localparam logic [SET_W-1:0] RST_TARGET_HUMIDITY      = 10'd500;
  localparam logic [SET_W-1:0] RST_TARGET_OXYGEN        = 10'd300;
  localparam logic [SET_W-1:0] RST_BAND                 = 10'd50;
  localparam logic [CO2_W-1:0] RST_CARBON_DIOXIDE_LIMIT = 16'd5000;
  localparam logic [SAT_W-1:0] RST_SATURATION_LIMIT     = 7'd85;

  // persistence checks, one counter each
  localparam int CHK_TEMP_HIGH = 0;
  localparam int CHK_TEMP_LOW  = 1;
  localparam int CHK_HUMIDITY  = 2;
  localparam int CHK_OXYGEN    = 3;
  localparam int CHK_CO2       = 4;
  localparam int CHK_PULSE     = 5;
  localparam int CHK_SAT       = 6;

  // alarm bit positions
  localparam int BIT_TEMP_HIGH = 0;
  localparam int BIT_TEMP_LOW  = 1;
  localparam int BIT_HUMID     = 2;
  localparam int BIT_GAS       = 3;
  localparam int BIT_PULSE     = 4;
  localparam int BIT_SAT       = 5;
  localparam int BIT_COMM      = 6;

  // timing and limit constants
  localparam logic [CNT_W-1:0]   SLOW_DELAY  = 7'd100;
  localparam logic [CNT_W-1:0]   FAST_DELAY  = 7'd30;
  localparam logic [GRACE_W-1:0] GRACE_TICKS = 6'd50;
  localparam logic [HR_W-1:0]    PULSE_LOW   = 8'd50;
  localparam logic [HR_W-1:0]    PULSE_HIGH  = 8'd140;
  localparam logic signed [TEMP_W-1:0] TEMP_INVALID = -12'sd999;
  localparam logic [PHASE_W-1:0] BLINK_PERIOD = 4'd10;
  localparam logic [PHASE_W-1:0] BLINK_ON     = 4'd5;

  // delay each counter must reach, indexed by check
  localparam logic [NUM_CHECKS-1:0][CNT_W-1:0] CHECK_DELAY = {
    FAST_DELAY,  // saturation
    FAST_DELAY,  // pulse
    SLOW_DELAY,  // co2
    SLOW_DELAY,  // oxygen
    SLOW_DELAY,  // humidity
    SLOW_DELAY,  // temperature low
    SLOW_DELAY   // temperature high
  };

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic [SET_W-1:0]         humidity;
    logic [SET_W-1:0]         oxygen;
    logic                     gas_sensor_ok;
    logic [CO2_W-1:0]         carbon_dioxide;
    logic                     co2_sensor_ok;
    logic [HR_W-1:0]          heart_rate;
    logic [SAT_W-1:0]         saturation;
    logic                     pulse_sensor_ok;
    logic                     screen_online;
    logic                     ack_key;
    logic                     timer_beep;
  } snap_t;

  typedef struct packed {
    logic [SET_W-1:0] target_temperature;
    logic [SET_W-1:0] target_humidity;
    logic [SET_W-1:0] target_oxygen;
    logic [SET_W-1:0] temperature_band;
    logic [SET_W-1:0] humidity_band;
    logic [SET_W-1:0] oxygen_band;
    logic [CO2_W-1:0] carbon_dioxide_limit;
    logic [SAT_W-1:0] saturation_limit;
  } cfg_t;

  typedef struct packed {
    logic [NUM_CHECKS-1:0][CNT_W-1:0] cnt;
    logic [GRACE_W-1:0]               grace_seen;
    logic [ALARM_W-1:0]               latched;
    logic                             ack;
    logic [PHASE_W-1:0]               phase;
  } state_t;

  typedef struct packed {
    logic [ALARM_W-1:0] alarm_bits;
    logic               buzzer_request;
    logic               buzzer_drive;
    logic               acknowledged_out;
  } result_t;

  // setpoint plus band, signed and without wrap
  function automatic logic signed [CMP_W-1:0] band_upper(
    input logic [SET_W-1:0] set, input logic [SET_W-1:0] band);
    return $signed({3'b000, set}) + $signed({3'b000, band});
  endfunction

  // setpoint minus band, may go negative
  function automatic logic signed [CMP_W-1:0] band_lower(
    input logic [SET_W-1:0] set, input logic [SET_W-1:0] band);
    return $signed({3'b000, set}) - $signed({3'b000, band});
  endfunction

endpackage

// ===== sv/vsal_step.sv =====
`timescale 1ns / 1ps

// one tick of the alarm logic: checks, counters, latch, ack and buzzer
module vsal_step (
  input  vsal_pkg::cfg_t    cfg,
  input  vsal_pkg::state_t  st,
  input  vsal_pkg::snap_t   snap,
  output vsal_pkg::state_t  st_nxt,
  output vsal_pkg::result_t res
);

  logic signed [vsal_pkg::CMP_W-1:0] temp_ext;
  logic signed [vsal_pkg::CMP_W-1:0] hum_ext;
  logic signed [vsal_pkg::CMP_W-1:0] oxy_ext;
  logic [vsal_pkg::NUM_CHECKS-1:0]   cond;
  logic [vsal_pkg::NUM_CHECKS-1:0]   hit;
  logic [vsal_pkg::ALARM_W-1:0]      flags;
  logic [vsal_pkg::ALARM_W-1:0]      latched_or;
  logic [vsal_pkg::ALARM_W-1:0]      latched_fin;
  logic [vsal_pkg::PHASE_W-1:0]      phase_inc;
  logic                              tvalid;
  logic                              grace;
  logic                              ack_in;
  logic                              ack_fin;
  logic                              request;

  // widen readings to a common signed compare width
  assign temp_ext = {snap.temperature[vsal_pkg::TEMP_W-1], snap.temperature};
  assign hum_ext  = $signed({3'b000, snap.humidity});
  assign oxy_ext  = $signed({3'b000, snap.oxygen});
  assign tvalid   = snap.temperature != vsal_pkg::TEMP_INVALID;

  // raw check conditions for this tick
  always_comb begin
    cond = '0;
    cond[vsal_pkg::CHK_TEMP_HIGH] = tvalid && (temp_ext >
      vsal_pkg::band_upper(cfg.target_temperature, cfg.temperature_band));
    cond[vsal_pkg::CHK_TEMP_LOW] = tvalid && (temp_ext <
      vsal_pkg::band_lower(cfg.target_temperature, cfg.temperature_band));
    cond[vsal_pkg::CHK_HUMIDITY] = snap.gas_sensor_ok &&
      ((hum_ext > vsal_pkg::band_upper(cfg.target_humidity, cfg.humidity_band)) ||
       (hum_ext < vsal_pkg::band_lower(cfg.target_humidity, cfg.humidity_band)));
    cond[vsal_pkg::CHK_OXYGEN] = snap.gas_sensor_ok &&
      ((oxy_ext > vsal_pkg::band_upper(cfg.target_oxygen, cfg.oxygen_band)) ||
       (oxy_ext < vsal_pkg::band_lower(cfg.target_oxygen, cfg.oxygen_band)));
    cond[vsal_pkg::CHK_CO2] = snap.co2_sensor_ok &&
      (snap.carbon_dioxide > cfg.carbon_dioxide_limit);
    cond[vsal_pkg::CHK_PULSE] = snap.pulse_sensor_ok && (snap.heart_rate != '0) &&
      ((snap.heart_rate < vsal_pkg::PULSE_LOW) || (snap.heart_rate > vsal_pkg::PULSE_HIGH));
    cond[vsal_pkg::CHK_SAT] = snap.pulse_sensor_ok && (snap.saturation != '0) &&
      (snap.saturation < cfg.saturation_limit);
  end

  // persistence counters, saturating at their delay
  always_comb begin
    for (int i = 0; i < vsal_pkg::NUM_CHECKS; i++) begin
      if (!cond[i]) begin
        st_nxt.cnt[i] = '0;
      end else if (st.cnt[i] < vsal_pkg::CHECK_DELAY[i]) begin
        st_nxt.cnt[i] = st.cnt[i] + 7'd1;
      end else begin
        st_nxt.cnt[i] = st.cnt[i];
      end
      hit[i] = cond[i] && (st_nxt.cnt[i] >= vsal_pkg::CHECK_DELAY[i]);
    end
  end

  // startup grace period for the comm check
  assign grace = st.grace_seen < vsal_pkg::GRACE_TICKS;
  assign st_nxt.grace_seen = grace ? st.grace_seen + 6'd1 : st.grace_seen;

  // map checks onto alarm bits
  always_comb begin
    flags = '0;
    flags[vsal_pkg::BIT_TEMP_HIGH] = hit[vsal_pkg::CHK_TEMP_HIGH];
    flags[vsal_pkg::BIT_TEMP_LOW]  = hit[vsal_pkg::CHK_TEMP_LOW];
    flags[vsal_pkg::BIT_HUMID]     = hit[vsal_pkg::CHK_HUMIDITY];
    flags[vsal_pkg::BIT_GAS]       = hit[vsal_pkg::CHK_OXYGEN] | hit[vsal_pkg::CHK_CO2];
    flags[vsal_pkg::BIT_PULSE]     = hit[vsal_pkg::CHK_PULSE];
    flags[vsal_pkg::BIT_SAT]       = hit[vsal_pkg::CHK_SAT];
    flags[vsal_pkg::BIT_COMM]      = !grace && !snap.screen_online;
  end

  // latch, then clear absent conditions once acknowledged
  assign ack_in      = st.ack | snap.ack_key;
  assign latched_or  = st.latched | flags;
  assign latched_fin = ack_in ? (latched_or & flags) : latched_or;
  assign ack_fin     = ack_in && (latched_fin != '0);
  assign request     = (latched_fin != '0) && !ack_fin;

  assign st_nxt.latched = latched_fin;
  assign st_nxt.ack     = ack_fin;

  // buzzer blink, timer beep overrides and holds the phase
  assign phase_inc = st.phase + 4'd1;

  always_comb begin
    if (snap.timer_beep) begin
      st_nxt.phase     = st.phase;
      res.buzzer_drive = 1'b1;
    end else if (request) begin
      st_nxt.phase     = (phase_inc >= vsal_pkg::BLINK_PERIOD) ? '0 : phase_inc;
      res.buzzer_drive = st_nxt.phase < vsal_pkg::BLINK_ON;
    end else begin
      st_nxt.phase     = '0;
      res.buzzer_drive = 1'b0;
    end
  end

  assign res.alarm_bits       = latched_fin;
  assign res.buzzer_request   = request;
  assign res.acknowledged_out = ack_fin;

endmodule

// ===== sv/vital_sign_alarm_latch_core.sv =====
`timescale 1ns / 1ps

// Vital-sign alarm latch: one input transaction is one 100 ms tick with a sensor snapshot,
// and each tick gives exactly one result transaction with the latched alarm bits and the
// buzzer controls. Configuration registers are written through cfg_we/cfg_index/cfg_wdata
// and take effect from the next tick; write them only while no tick is in flight. The block
// takes one tick every clock cycle while the result side is not stalled: a tick is held in an input
// register, runs combinationally through the check, latch and buzzer logic while the alarm state
// updates, and lands in a result register. The registered state update is the loop that sets
// this rate. A full result register that is not taken stalls the input register, and once the
// input register is full the input side stops accepting while the result waits.
module vital_sign_alarm_latch_core (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // snapshot channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] in_temperature,
  input  logic [9:0]  in_humidity,
  input  logic [9:0]  in_oxygen,
  input  logic        in_gas_sensor_ok,
  input  logic [15:0] in_carbon_dioxide,
  input  logic        in_co2_sensor_ok,
  input  logic [7:0]  in_heart_rate,
  input  logic [6:0]  in_saturation,
  input  logic        in_pulse_sensor_ok,
  input  logic        in_screen_online,
  input  logic        in_ack_key,
  input  logic        in_timer_beep,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_alarm_bits,
  output logic        out_buzzer_request,
  output logic        out_buzzer_drive,
  output logic        out_acknowledged_out
);

  `include "vital_sign_alarm_latch_core_macros.svh"

  vsal_pkg::cfg_t    cfg_r;
  vsal_pkg::state_t  st_r;
  vsal_pkg::state_t  st_nxt;
  vsal_pkg::snap_t   snap_r;
  vsal_pkg::result_t res_nxt;
  vsal_pkg::result_t res_r;
  logic              in_valid_r;
  logic              in_valid_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              in_take;
  logic              advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_temperature   <= vsal_pkg::RST_TARGET_TEMPERATURE;
      cfg_r.target_humidity      <= vsal_pkg::RST_TARGET_HUMIDITY;
      cfg_r.target_oxygen        <= vsal_pkg::RST_TARGET_OXYGEN;
      cfg_r.temperature_band     <= vsal_pkg::RST_BAND;
      cfg_r.humidity_band        <= vsal_pkg::RST_BAND;
      cfg_r.oxygen_band          <= vsal_pkg::RST_BAND;
      cfg_r.carbon_dioxide_limit <= vsal_pkg::RST_CARBON_DIOXIDE_LIMIT;
      cfg_r.saturation_limit     <= vsal_pkg::RST_SATURATION_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vsal_pkg::REG_TARGET_TEMPERATURE:   cfg_r.target_temperature <= cfg_wdata[9:0];
        vsal_pkg::REG_TARGET_HUMIDITY:      cfg_r.target_humidity <= cfg_wdata[9:0];
        vsal_pkg::REG_TARGET_OXYGEN:        cfg_r.target_oxygen <= cfg_wdata[9:0];
        vsal_pkg::REG_TEMPERATURE_BAND:     cfg_r.temperature_band <= cfg_wdata[9:0];
        vsal_pkg::REG_HUMIDITY_BAND:        cfg_r.humidity_band <= cfg_wdata[9:0];
        vsal_pkg::REG_OXYGEN_BAND:          cfg_r.oxygen_band <= cfg_wdata[9:0];
        vsal_pkg::REG_CARBON_DIOXIDE_LIMIT: cfg_r.carbon_dioxide_limit <= cfg_wdata;
        vsal_pkg::REG_SATURATION_LIMIT:     cfg_r.saturation_limit <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake: input register feeds result register
  assign advance       = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready      = !in_valid_r || advance;
  assign in_take       = in_valid && in_ready;
  assign in_valid_nxt  = in_take || (in_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_take) begin
      snap_r.temperature     <= $signed(in_temperature);
      snap_r.humidity        <= in_humidity;
      snap_r.oxygen          <= in_oxygen;
      snap_r.gas_sensor_ok   <= in_gas_sensor_ok;
      snap_r.carbon_dioxide  <= in_carbon_dioxide;
      snap_r.co2_sensor_ok   <= in_co2_sensor_ok;
      snap_r.heart_rate      <= in_heart_rate;
      snap_r.saturation      <= in_saturation;
      snap_r.pulse_sensor_ok <= in_pulse_sensor_ok;
      snap_r.screen_online   <= in_screen_online;
      snap_r.ack_key         <= in_ack_key;
      snap_r.timer_beep      <= in_timer_beep;
    end
  end

  // per-tick alarm logic
  vsal_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .snap   (snap_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // alarm state, updated as a tick moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_alarm_bits       = res_r.alarm_bits;
  assign out_buzzer_request   = res_r.buzzer_request;
  assign out_buzzer_drive     = res_r.buzzer_drive;
  assign out_acknowledged_out = res_r.acknowledged_out;

  // checks on the alarm state and results
  `VSAL_ASSERT_IMP(a_req_needs_alarm, out_valid_r && out_buzzer_request, (out_alarm_bits != '0) && !out_acknowledged_out, "buzzer request without an unacknowledged alarm")
  `VSAL_ASSERT_IMP(a_ack_needs_alarm, out_valid_r && out_acknowledged_out, out_alarm_bits != '0, "acknowledge held with no alarm latched")
  `VSAL_ASSERT(a_pulse_cnt_sat, st_r.cnt[vsal_pkg::CHK_PULSE] <= vsal_pkg::FAST_DELAY, "pulse counter past its delay")
  `VSAL_ASSERT(a_phase_range, st_r.phase < vsal_pkg::BLINK_PERIOD, "blink phase out of range")
  `VSAL_ASSERT_NXT(a_adv_fills_out, advance, out_valid_r && (out_alarm_bits == $past(st_nxt.latched)), "tick lost on its way to the result register")

endmodule
